FILE: rtl/hlv_pkg.sv
// Shared constants, types and state codes for the Hough line vote block.
`timescale 1ns / 1ps
package hlv_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;
  localparam int SUBSTEPS = 10;
  localparam int SPAN     = MAX_ROWS * SUBSTEPS;
  localparam int DEPTH    = SPAN * SPAN;
  localparam int AW       = $clog2(DEPTH);
  localparam int KB_W     = $clog2(DEPTH + 1);
  localparam int LW       = $clog2(SPAN + 1);
  localparam int VW       = LW + 2;
  localparam int RW       = $clog2(MAX_ROWS + 1);
  localparam int TOT_W    = 32;
  localparam int VAL_W    = 16;
  localparam int DF_W     = 17;
  localparam int PROD_W   = TOT_W + DF_W;
  localparam int FRAC_W   = 16;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  typedef enum logic {
    REG_DECAY = 1'b0,
    REG_ROWS  = 1'b1
  } hlv_reg_t;

  typedef enum logic [2:0] {
    ST_INIT_CLEAR,
    ST_IDLE,
    ST_CLEAR,
    ST_DECAY,
    ST_DECAY_WAIT,
    ST_VOTE,
    ST_EMIT
  } hlv_state_t;

  typedef struct packed {
    logic [DF_W-1:0] decay_factor;
    logic [4:0]      rows_in_use;
  } hlv_cfg_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
  } hlv_rd_t;

  typedef struct packed {
    logic             en;
    logic [AW-1:0]    addr;
    logic [TOT_W-1:0] data;
  } hlv_wr_t;

endpackage

FILE: rtl/hlv_if.sv
// Stream interfaces for cell beats in and result beats out.
`timescale 1ns / 1ps
interface hlv_in_if;
  logic               valid;
  logic               ready;
  logic               frame_start;
  logic [3:0]         row;
  logic [3:0]         col;
  logic signed [15:0] cell_value;
  logic               last_cell;

  modport source (output valid, frame_start, row, col, cell_value, last_cell, input ready);
  modport sink   (input valid, frame_start, row, col, cell_value, last_cell, output ready);
endinterface

interface hlv_out_if;
  logic              valid;
  logic              ready;
  logic              found;
  logic [7:0]        best_slope_tenths;
  logic signed [7:0] best_intercept_tenths;
  logic [30:0]       best_score;

  modport source (output valid, found, best_slope_tenths, best_intercept_tenths, best_score,
                  input ready);
  modport sink   (input valid, found, best_slope_tenths, best_intercept_tenths, best_score,
                  output ready);
endinterface

FILE: rtl/hlv_cfg_regs.sv
// APB register bank: decay factor and rows in use.
`timescale 1ns / 1ps
module hlv_cfg_regs import hlv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output hlv_cfg_t           cfg
);

  logic [DF_W-1:0] decay_r;
  logic [4:0]      rows_r;
  hlv_reg_t        idx;
  logic            wr;

  assign idx = hlv_reg_t'(paddr[2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= DF_W'(65536);
      rows_r  <= 5'(MAX_ROWS);
    end else if (wr) begin
      case (idx)
        REG_DECAY: decay_r <= pwdata[DF_W-1:0];
        REG_ROWS:  rows_r  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DECAY: prdata = PDATA_W'(decay_r);
      REG_ROWS:  prdata = PDATA_W'(rows_r);
      default:   prdata = '0;
    endcase
  end

  assign cfg.decay_factor = decay_r;
  assign cfg.rows_in_use  = rows_r;

endmodule

FILE: rtl/hlv_vote_mem.sv
// Vote store: one write port, one registered read port.
`timescale 1ns / 1ps
module hlv_vote_mem import hlv_pkg::*; (
  input  logic             clk,
  input  hlv_rd_t          rd,
  output logic [TOT_W-1:0] rd_data,
  input  hlv_wr_t          wr
);

  logic [TOT_W-1:0] mem [DEPTH];
  logic [TOT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/hlv_decay_pipe.sv
// Decay pipeline: magnitude, scale by Q1.16 factor, restore sign, saturate.
`timescale 1ns / 1ps
module hlv_decay_pipe import hlv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [DF_W-1:0]  decay_factor,
  input  hlv_rd_t          issue,
  input  logic [TOT_W-1:0] rd_data,
  output hlv_wr_t          wr,
  output logic             busy
);

  logic              s1_v_r, s2_v_r, s3_v_r;
  logic [AW-1:0]     s1_addr_r, s2_addr_r, s3_addr_r;
  logic              s2_neg_r, s3_neg_r;
  logic [TOT_W-1:0]  s2_mag_r;
  logic [PROD_W-1:0] s3_prod_r;
  logic              s1_neg;
  logic [TOT_W-1:0]  s1_mag;
  logic [TOT_W:0]    scaled;
  logic [TOT_W-1:0]  result;

  // read data lines up with stage 1
  assign s1_neg = rd_data[TOT_W-1];
  assign s1_mag = s1_neg ? (TOT_W'(0) - rd_data) : rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue.en;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= issue.addr;
    s2_addr_r <= s1_addr_r;
    s2_neg_r  <= s1_neg;
    s2_mag_r  <= s1_mag;
    s3_addr_r <= s2_addr_r;
    s3_neg_r  <= s2_neg_r;
    s3_prod_r <= PROD_W'(s2_mag_r) * PROD_W'(decay_factor);
  end

  assign scaled = s3_prod_r[PROD_W-1:FRAC_W];

  always_comb begin
    if (s3_neg_r) begin
      if (scaled > (TOT_W+1)'(33'h0_8000_0000)) result = 32'h8000_0000;
      else                                      result = TOT_W'(0) - scaled[TOT_W-1:0];
    end else begin
      if (scaled > (TOT_W+1)'(33'h0_7FFF_FFFF)) result = 32'h7FFF_FFFF;
      else                                      result = scaled[TOT_W-1:0];
    end
  end

  assign wr.en   = s3_v_r;
  assign wr.addr = s3_addr_r;
  assign wr.data = result;
  assign busy    = s1_v_r || s2_v_r || s3_v_r;

endmodule

FILE: rtl/hlv_ctrl.sv
// Sequencer: store sweeps, slope sweep with read-modify-write, best tracking, result.
`timescale 1ns / 1ps
module hlv_ctrl import hlv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  hlv_cfg_t         cfg,
  hlv_in_if.sink           in_chan,
  hlv_out_if.source        out_chan,
  output hlv_rd_t          mem_rd,
  input  logic [TOT_W-1:0] mem_rdata,
  output hlv_wr_t          mem_wr,
  output hlv_rd_t          dcy_rd,
  input  hlv_wr_t          dcy_wr,
  input  logic             dcy_busy
);

  hlv_state_t state_r, state_nxt;

  logic [AW-1:0]          addr_r;
  logic                   init_r, zero_r, last_r, active_r;
  logic signed [VAL_W-1:0] val_r;
  logic [3:0]             col_r;
  logic [LW-1:0]          k_r, limit_r;
  logic signed [VW-1:0]   v_r;
  logic [VW-1:0]          base_r;
  logic [KB_W-1:0]        kbase_r;
  logic                   pend_r;
  logic [AW-1:0]          pend_addr_r;
  logic [LW-1:0]          pend_k_r;
  logic [7:0]             pend_icpt_r;
  logic signed [TOT_W-1:0] best_total_r;
  logic [7:0]             best_slope_r, best_icpt_r;
  logic                   out_valid_r, out_found_r;
  logic [7:0]             out_slope_r, out_icpt_r;
  logic [30:0]            out_score_r;

  logic                   accept, sweep_last, vote_done, vote_hit, out_free, in_sweep;
  logic [RW-1:0]          rows_eff;
  logic [LW-1:0]          limit_in;
  logic [VW-1:0]          base_in, row10, v0;
  logic [AW-1:0]          vote_addr;
  logic signed [TOT_W:0]  sum_wide;
  logic signed [TOT_W-1:0] sum_sat;
  logic [VW-1:0]          icpt_wide;

  assign accept     = in_chan.valid && in_chan.ready;
  assign sweep_last = (addr_r == AW'(DEPTH - 1));
  assign out_free   = !out_valid_r || out_chan.ready;
  assign in_sweep   = (state_r == ST_INIT_CLEAR) || (state_r == ST_CLEAR) ||
                      (state_r == ST_DECAY);

  assign rows_eff = (cfg.rows_in_use > 5'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(cfg.rows_in_use);
  assign limit_in = LW'(rows_eff) * LW'(SUBSTEPS);
  assign base_in  = VW'(rows_eff >> 1) * VW'(SUBSTEPS);
  assign row10    = VW'(in_chan.row) * VW'(SUBSTEPS);
  assign v0       = row10 + base_in - VW'(in_chan.col);

  // sweep ends at once for an inactive cell, else at the slope limit or at the first negative intercept index
  assign vote_done = !active_r || (k_r >= limit_r) || v_r[VW-1];
  assign vote_hit  = (state_r == ST_VOTE) && !vote_done && (v_r < $signed(VW'(limit_r)));
  assign vote_addr = kbase_r[AW-1:0] + AW'(v_r[LW-1:0]);
  assign icpt_wide = v_r - base_r;

  // saturating vote add on the data read last cycle
  assign sum_wide = {mem_rdata[TOT_W-1], mem_rdata} + (TOT_W+1)'(val_r);
  always_comb begin
    if (sum_wide[TOT_W] != sum_wide[TOT_W-1]) begin
      sum_sat = sum_wide[TOT_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum_wide[TOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_INIT_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT_CLEAR: if (sweep_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_chan.frame_start) begin
            if (init_r)      state_nxt = ST_DECAY;
            else if (zero_r) state_nxt = ST_VOTE;
            else             state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_VOTE;
          end
        end
      end
      ST_CLEAR:      if (sweep_last) state_nxt = ST_VOTE;
      ST_DECAY:      if (sweep_last) state_nxt = ST_DECAY_WAIT;
      ST_DECAY_WAIT: if (!dcy_busy) state_nxt = ST_VOTE;
      ST_VOTE:       if (vote_done) state_nxt = last_r ? ST_EMIT : ST_IDLE;
      ST_EMIT:       if (out_free) state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = (state_r == ST_IDLE);

    dcy_rd.en   = (state_r == ST_DECAY);
    dcy_rd.addr = addr_r;

    mem_rd.en   = (state_r == ST_DECAY) || vote_hit;
    mem_rd.addr = (state_r == ST_DECAY) ? addr_r : vote_addr;

    if ((state_r == ST_INIT_CLEAR) || (state_r == ST_CLEAR)) begin
      mem_wr.en   = 1'b1;
      mem_wr.addr = addr_r;
      mem_wr.data = '0;
    end else if (dcy_wr.en) begin
      mem_wr = dcy_wr;
    end else begin
      mem_wr.en   = pend_r;
      mem_wr.addr = pend_addr_r;
      mem_wr.data = sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r       <= '0;
      init_r       <= 1'b0;
      zero_r       <= 1'b0;
      pend_r       <= 1'b0;
      best_total_r <= '0;
      best_slope_r <= '0;
      best_icpt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_sweep) begin
        addr_r <= sweep_last ? '0 : addr_r + AW'(1);
      end
      if (((state_r == ST_INIT_CLEAR) || (state_r == ST_CLEAR)) && sweep_last) begin
        zero_r <= 1'b1;
      end else if (pend_r) begin
        zero_r <= 1'b0;
      end

      pend_r <= vote_hit;

      if (accept && in_chan.frame_start) begin
        init_r       <= 1'b1;
        best_total_r <= '0;
        best_slope_r <= '0;
        best_icpt_r  <= '0;
      end else if (pend_r && (sum_sat > best_total_r)) begin
        best_total_r <= sum_sat;
        best_slope_r <= 8'(pend_k_r);
        best_icpt_r  <= pend_icpt_r;
      end

      if ((state_r == ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_r    <= in_chan.cell_value;
      col_r    <= in_chan.col;
      last_r   <= in_chan.last_cell;
      active_r <= (in_chan.cell_value != '0) && (RW'(in_chan.row) < rows_eff);
      limit_r  <= limit_in;
      base_r   <= base_in;
      k_r      <= LW'(1);
      v_r      <= $signed(v0);
      kbase_r  <= KB_W'(SPAN);
    end else if ((state_r == ST_VOTE) && !vote_done) begin
      k_r     <= k_r + LW'(1);
      v_r     <= v_r - $signed(VW'(col_r));
      kbase_r <= kbase_r + KB_W'(SPAN);
    end
    if (vote_hit) begin
      pend_addr_r <= vote_addr;
      pend_k_r    <= k_r;
      pend_icpt_r <= icpt_wide[7:0];
    end
    if ((state_r == ST_EMIT) && out_free) begin
      out_found_r <= (best_total_r != '0);
      out_slope_r <= best_slope_r;
      out_icpt_r  <= best_icpt_r;
      out_score_r <= best_total_r[30:0];
    end
  end

  assign out_chan.valid                 = out_valid_r;
  assign out_chan.found                 = out_found_r;
  assign out_chan.best_slope_tenths     = out_slope_r;
  assign out_chan.best_intercept_tenths = $signed(out_icpt_r);
  assign out_chan.best_score            = out_score_r;

endmodule

FILE: rtl/hough_line_vote_with_decay.sv
// Top level of the Hough line vote block with frame decay.
`timescale 1ns / 1ps
// Takes one similarity cell per beat and votes it into a 160 x 160 store of
// 32-bit totals (slope in tenths by intercept index), at most one
// read-modify-write of the single-port-read vote memory per slope step. A
// nonzero cell inside the matrix steps through up to 10 * rows - 1 slopes (159
// at 16 rows), ending early at the first negative intercept index; other cells
// end their sweep at once. A frame-start beat first sweeps the whole store, one
// entry a cycle, to clear it on the first frame (skipped while it is still all
// zero) or to scale it by the decay factor on later frames. After reset the
// store is cleared in one pass over all 25600 entries during which no cell beat
// is taken; register writes are accepted throughout. A last-cell beat produces
// one result beat, held in an output register until taken.
module hough_line_vote_with_decay import hlv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  hlv_in_if.sink             in_chan,
  hlv_out_if.source          out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  hlv_cfg_t         cfg;
  hlv_rd_t          mem_rd, dcy_rd;
  hlv_wr_t          mem_wr, dcy_wr;
  logic [TOT_W-1:0] mem_rdata;
  logic             dcy_busy;

  assign pready = 1'b1;

  hlv_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  hlv_vote_mem u_mem (
    .clk     (clk),
    .rd      (mem_rd),
    .rd_data (mem_rdata),
    .wr      (mem_wr)
  );

  hlv_decay_pipe u_decay (
    .clk          (clk),
    .rst_n        (rst_n),
    .decay_factor (cfg.decay_factor),
    .issue        (dcy_rd),
    .rd_data      (mem_rdata),
    .wr           (dcy_wr),
    .busy         (dcy_busy)
  );

  hlv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .mem_rd    (mem_rd),
    .mem_rdata (mem_rdata),
    .mem_wr    (mem_wr),
    .dcy_rd    (dcy_rd),
    .dcy_wr    (dcy_wr),
    .dcy_busy  (dcy_busy)
  );

endmodule

FILE: tb/hough_line_vote_with_decay_tb.sv
// Self-checking testbench for the Hough line vote block with frame decay.
`timescale 1ns / 1ps
module hough_line_vote_with_decay_tb;
  import hlv_pkg::*;

  typedef struct packed {
    logic               frame_start;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
    logic               last;
  } cell_t;

  typedef struct packed {
    logic              found;
    logic [7:0]        slope;
    logic signed [7:0] intercept;
    logic [30:0]       score;
  } line_t;

  logic clk;
  logic rst_n = 1'b0;

  hlv_in_if  in_chan ();
  hlv_out_if out_chan ();

  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic  in_valid  = 1'b0;
  cell_t in_beat   = '0;
  logic  out_ready = 1'b0;
  logic  steady    = 1'b0;

  assign in_chan.valid       = in_valid;
  assign in_chan.frame_start = in_beat.frame_start;
  assign in_chan.row         = in_beat.row;
  assign in_chan.col         = in_beat.col;
  assign in_chan.cell_value  = in_beat.value;
  assign in_chan.last_cell   = in_beat.last;
  assign out_chan.ready      = out_ready;

  hough_line_vote_with_decay DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  cell_t cell_q[$];
  line_t line_q[$];
  int    mismatches = 0;

  // shadow of the block: vote totals, best line, registers
  int              votes [DEPTH];
  bit              store_ready = 1'b0;
  int              best_total  = 0;
  int              best_k      = 0;
  int              best_v      = 0;
  logic [DF_W-1:0] decay_reg   = 17'd65536;
  logic [4:0]      rows_reg    = 5'd16;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  // magnitude scaled and truncated, sign put back, then saturated
  function automatic int decayed(int t);
    longint mag;
    longint p;
    mag = (t < 0) ? -longint'(t) : longint'(t);
    p = (mag * longint'(decay_reg)) >> FRAC_W;
    return clamp32((t < 0) ? -p : p);
  endfunction

  function automatic int rows_live();
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
  endfunction

  function automatic void tally_cell(cell_t c);
    int rows;
    int lim;
    int base;
    int v;
    int idx;
    rows = rows_live();
    if (c.frame_start) begin
      if (!store_ready) begin
        foreach (votes[i]) votes[i] = 0;
        store_ready = 1'b1;
      end else begin
        foreach (votes[i]) votes[i] = decayed(votes[i]);
      end
      best_total = 0;
      best_k     = 0;
      best_v     = 0;
    end
    if (c.value != 0 && int'(c.row) < rows) begin
      lim  = SUBSTEPS * rows;
      base = SUBSTEPS * (rows / 2);
      for (int k = 1; k < lim; k++) begin
        v = SUBSTEPS * int'(c.row) - k * int'(c.col) + base;
        if (v < 0) break;
        if (v < lim) begin
          idx = k * SPAN + v;
          votes[idx] = clamp32(longint'(votes[idx]) + longint'($signed(c.value)));
          if (votes[idx] > best_total) begin
            best_total = votes[idx];
            best_k     = k;
            best_v     = v - base;
          end
        end
      end
    end
    if (c.last)
      line_q.push_back('{found: (best_total > 0), slope: best_k[7:0],
                         intercept: best_v[7:0], score: best_total[30:0]});
  endfunction

  // cell driver: a beat is predicted at the edge that takes it
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_chan.ready) tally_cell(in_beat);
      if (!in_valid || in_chan.ready) begin
        if (cell_q.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
          in_beat  <= cell_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void match_line();
    line_t want;
    if (line_q.size() == 0) begin
      $error("result beat with no line expected");
      mismatches++;
      return;
    end
    want = line_q.pop_front();
    if (out_chan.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, out_chan.found);
      mismatches++;
    end
    if (out_chan.best_slope_tenths !== want.slope) begin
      $error("best_slope_tenths: expected %0d, got %0d", want.slope,
             out_chan.best_slope_tenths);
      mismatches++;
    end
    if (out_chan.best_intercept_tenths !== want.intercept) begin
      $error("best_intercept_tenths: expected %0d, got %0d", want.intercept,
             out_chan.best_intercept_tenths);
      mismatches++;
    end
    if (out_chan.best_score !== want.score) begin
      $error("best_score: expected %0d, got %0d", want.score, out_chan.best_score);
      mismatches++;
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_ready) match_line();
      out_ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  task automatic write_reg(input hlv_reg_t idx, input int data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DECAY: decay_reg = data[DF_W-1:0];
      REG_ROWS:  rows_reg  = data[4:0];
      default: ;
    endcase
  endtask

  // drain everything, then give the block time to go quiet
  task automatic settle();
    while (cell_q.size() != 0 || in_valid || line_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  function automatic void add(bit fs, int row, int col, int val, bit last);
    cell_q.push_back('{frame_start: fs, row: row[3:0], col: col[3:0],
                       value: val[15:0], last: last});
  endfunction

  function automatic cell_t rand_cell(int rows);
    cell_t c;
    int    pick;
    c.frame_start = 1'b0;
    c.last        = ($urandom_range(99) < 8);
    if (rows > 0 && $urandom_range(9) != 0) c.row = 4'($urandom_range(rows - 1));
    else c.row = 4'($urandom_range(15));
    c.col = 4'($urandom_range(15));
    pick  = $urandom_range(9);
    if (pick == 0) c.value = '0;
    else if (pick == 1) c.value = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    else if (pick < 6) c.value = 16'($urandom);
    else c.value = 16'($urandom_range(2000)) - 16'd1000;
    return c;
  endfunction

  initial begin
    cell_t c;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: votes ahead of any frame, first-frame clear, ties
    add(0, 3, 2, 1000, 1);
    add(1, 15, 15, 32767, 1);
    add(0, 5, 5, 0, 1);
    add(0, 15, 15, -32768, 0);
    add(0, 0, 0, 32767, 0);
    add(0, 0, 15, -1, 1);
    settle();
    write_reg(REG_DECAY, 32768);
    write_reg(REG_ROWS, 5);
    add(1, 2, 3, 20000, 0);
    add(0, 5, 1, 12345, 1);   // row past the rows in use
    add(0, 4, 1, -300, 1);
    settle();
    write_reg(REG_ROWS, 0);
    write_reg(REG_DECAY, 0);
    add(1, 0, 0, 5000, 1);
    settle();
    write_reg(REG_ROWS, 1);
    write_reg(REG_DECAY, 65535);
    add(0, 0, 0, 777, 1);
    add(1, 0, 9, 100, 1);     // first step already negative
    settle();
    write_reg(REG_ROWS, 31);
    write_reg(REG_DECAY, 65536);
    add(1, 15, 0, 32767, 1);  // frame start and last cell on one beat
    add(0, 10, 8, -32768, 0);
    add(0, 9, 6, 16'h5a5a, 1);
    settle();

    // near-doubling decay drives both signs of totals into saturation
    write_reg(REG_ROWS, 2);
    write_reg(REG_DECAY, 131071);
    for (int f = 0; f < 13; f++)
      for (int i = 0; i < 48; i++)
        add(i == 0, 0, i % 2, (i % 2) ? -32768 : 32767, i == 47);
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin write_reg(REG_DECAY, 0); write_reg(REG_ROWS, 16); end
        1: begin write_reg(REG_DECAY, 65536); write_reg(REG_ROWS, 3); end
        2: begin
          write_reg(REG_DECAY, $urandom_range(65536));
          write_reg(REG_ROWS, $urandom_range(16, 2));
        end
        3: begin
          write_reg(REG_DECAY, $urandom_range(131071));
          write_reg(REG_ROWS, $urandom_range(16, 2));
        end
        default: begin
          write_reg(REG_DECAY, $urandom_range(65536));
          write_reg(REG_ROWS, $urandom_range(31));
        end
      endcase
      @(negedge clk);
      steady = (p == 1);
      for (int f = 0; f < 2; f++)
        for (int i = 0; i < 130; i++) begin
          c = rand_cell(rows_live());
          c.frame_start = (i == 0);
          // some frames end without a result; the phase always ends with one
          if (i == 129 && (f == 1 || $urandom_range(3) != 0)) c.last = 1'b1;
          cell_q.push_back(c);
        end
      settle();
      steady = 1'b0;
    end

    if (mismatches == 0) begin
      $display("hough_line_vote_with_decay_tb OK");
    end else begin
      $display("hough_line_vote_with_decay_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("hough_line_vote_with_decay_tb NOT OK");
    $finish;
  end

endmodule

FILE: files.f
rtl/hlv_pkg.sv
rtl/hlv_if.sv
rtl/hlv_cfg_regs.sv
rtl/hlv_vote_mem.sv
rtl/hlv_decay_pipe.sv
rtl/hlv_ctrl.sv
rtl/hough_line_vote_with_decay.sv
tb/hough_line_vote_with_decay_tb.sv
